// ===== rtl/core/xorshift128_range_generator_assert.svh =====
// Assertion macros for the xorshift128 range generator.
// Needs clk and rst_n in the scope of each use.
`ifndef XORSHIFT128_RANGE_GENERATOR_ASSERT_SVH
`define XORSHIFT128_RANGE_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define XSRG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xsrg assertion failed");

// Plain invariant, disabled during reset.
`define XSRG_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("xsrg invariant failed");

`endif

// ===== rtl/core/xsrg_pkg.sv =====
// Shared types, constants and the xorshift step for the range generator.
// No dependencies.
`default_nettype none
package xsrg_pkg;

    localparam logic [31:0] SEED_X = 32'd123456789;
    localparam logic [31:0] SEED_Y = 32'd362436069;
    localparam logic [31:0] SEED_Z = 32'd521288629;
    localparam logic [31:0] SEED_W = 32'd88675123;

    localparam logic [2:0] CMD_RAW32     = 3'd0;
    localparam logic [2:0] CMD_U64       = 3'd1;
    localparam logic [2:0] CMD_HALF_OPEN = 3'd2;
    localparam logic [2:0] CMD_CLOSED    = 3'd3;
    localparam logic [2:0] CMD_PAIR      = 3'd4;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] lo_bound;
        logic [32:0] width;
        logic [31:0] draw_a;
        logic [31:0] draw_b;
        logic        err;
    } job_t;

    typedef struct packed {
        logic              full;
        logic [QCNT_W-1:0] count;
    } qstat_t;

    // New w of one xorshift128 step, from the old x and w.
    function automatic logic [31:0] xs_next(input logic [31:0] x, input logic [31:0] w);
        logic [31:0] t;
        t = x ^ (x << 11);
        return (w ^ (w >> 19)) ^ (t ^ (t >> 8));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/xorshift128_range_generator.sv =====
// Top level of the xorshift128 range generator: front, job queue, back end.
// Uses xsrg_pkg, xsrg_front, xsrg_queue, xsrg_back and the assertion header.
//
// channel   dir  tdata (low bit up)                     tuser
// s_axis    in   range_begin[31:0], range_end[63:32]    command[2:0]
// m_axis    out  word[63:0], first_value[95:64],        error[0]
//                second_value[127:96]
//
// One request per cycle sustained while m_axis_tready stays high; a result
// passes the queue write, the multiply stage and the output register before
// it is presented.
// Both xorshift steps of a request happen in the front in the transfer cycle.
// Reset loads the seeds and empties queue and pipeline.
// A stalled output fills the back end, then the four-entry queue, then
// drops s_axis_tready.
`default_nettype none
module xorshift128_range_generator (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,   // range_begin, range_end
    input  wire logic [2:0]   s_axis_tuser,   // command
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,   // word, first_value, second_value
    output logic [0:0]        m_axis_tuser    // error
);
    import xsrg_pkg::*;

    qstat_t      q_stat;
    logic        push, head_valid, pop;
    job_t        push_job, head_job;
    logic [63:0] res_word;
    logic [31:0] res_first, res_second;
    logic        res_error;

    xsrg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req_cmd   (s_axis_tuser),
        .req_begin (s_axis_tdata[31:0]),
        .req_end   (s_axis_tdata[63:32]),
        .q_stat    (q_stat),
        .push      (push),
        .push_job  (push_job)
    );

    xsrg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .q_stat     (q_stat),
        .head_valid (head_valid),
        .pop        (pop),
        .head_job   (head_job)
    );

    xsrg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (head_valid),
        .job_pop    (pop),
        .job        (head_job),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res_word   (res_word),
        .res_first  (res_first),
        .res_second (res_second),
        .res_error  (res_error)
    );

    assign m_axis_tdata = {res_second, res_first, res_word};
    assign m_axis_tuser = res_error;

`include "xorshift128_range_generator_assert.svh"

    `XSRG_ASSERT_IMP(a_err_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 128'd0)
    `XSRG_ASSERT_IMP(a_word_excl, m_axis_tvalid && |m_axis_tdata[63:0], !(|m_axis_tdata[127:64]))
    `XSRG_ASSERT_ALWAYS(a_q_count, q_stat.count <= QCNT_W'(QDEPTH))

endmodule
`default_nettype wire

// ===== rtl/core/xsrg_front.sv =====
// Front end: takes requests, checks ranges, advances the generator state.
// Uses xsrg_pkg; feeds xsrg_queue.
`default_nettype none
module xsrg_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire logic [2:0]    req_cmd,
    input  wire logic [31:0]   req_begin,
    input  wire logic [31:0]   req_end,
    input  wire xsrg_pkg::qstat_t q_stat,
    output logic               push,
    output xsrg_pkg::job_t     push_job
);
    import xsrg_pkg::*;

    logic [31:0] x_reg, y_reg, z_reg, w_reg;
    logic [31:0] x_next, y_next, z_next, w_next;
    logic [31:0] draw1, draw2;
    logic [32:0] diff;
    logic        diff_pos, diff_nonneg, diff_ge2;
    logic [1:0]  ndraw;
    logic        bad;
    logic [32:0] width;

    assign req_ready = !q_stat.full;
    assign push      = req_valid && req_ready;

    assign draw1 = xs_next(x_reg, w_reg);
    assign draw2 = xs_next(y_reg, draw1);

    assign diff        = {req_end[31], req_end} - {req_begin[31], req_begin};
    assign diff_nonneg = !diff[32];
    assign diff_pos    = diff_nonneg && (diff != 33'd0);
    assign diff_ge2    = diff_nonneg && (diff[32:1] != 32'd0);

    always_comb
    begin
        bad   = 1'b0;
        ndraw = 2'd0;
        width = diff;
        unique case (req_cmd)
            CMD_RAW32:     ndraw = 2'd1;
            CMD_U64:       ndraw = 2'd2;
            CMD_HALF_OPEN:
            begin
                bad   = !diff_pos;
                ndraw = diff_pos ? 2'd1 : 2'd0;
            end
            CMD_CLOSED:
            begin
                bad   = !diff_nonneg;
                ndraw = diff_nonneg ? 2'd1 : 2'd0;
                width = diff + 33'd1;
            end
            CMD_PAIR:
            begin
                bad   = !diff_ge2;
                ndraw = diff_ge2 ? 2'd2 : 2'd0;
            end
            default:       bad = 1'b1;
        endcase
    end

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        w_next = w_reg;
        if (push)
        begin
            unique case (ndraw)
                2'd1:
                begin
                    x_next = y_reg;
                    y_next = z_reg;
                    z_next = w_reg;
                    w_next = draw1;
                end
                2'd2:
                begin
                    x_next = z_reg;
                    y_next = w_reg;
                    z_next = draw1;
                    w_next = draw2;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= SEED_X;
            y_reg <= SEED_Y;
            z_reg <= SEED_Z;
            w_reg <= SEED_W;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            w_reg <= w_next;
        end
    end

    always_comb
    begin
        push_job.cmd      = req_cmd;
        push_job.lo_bound = req_begin;
        push_job.width    = width;
        push_job.draw_a   = draw1;
        push_job.draw_b   = draw2;
        push_job.err      = bad;
    end

endmodule
`default_nettype wire

// ===== rtl/core/xsrg_queue.sv =====
// Short job queue between front and back ends.
// Uses xsrg_pkg for the job type and depth.
`default_nettype none
module xsrg_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire xsrg_pkg::job_t  push_job,
    output xsrg_pkg::qstat_t     q_stat,
    output logic                 head_valid,
    input  wire logic            pop,
    output xsrg_pkg::job_t       head_job
);
    import xsrg_pkg::*;

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.count = count_reg;
    assign head_valid   = (count_reg != '0);
    assign head_job     = mem[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/xsrg_back.sv =====
// Back end: multiply-high scaling stage, then pair fold/sort and output register.
// Uses xsrg_pkg; drains xsrg_queue.
`default_nettype none
module xsrg_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            job_valid,
    output logic                 job_pop,
    input  wire xsrg_pkg::job_t  job,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output logic [63:0]          res_word,
    output logic [31:0]          res_first,
    output logic [31:0]          res_second,
    output logic                 res_error
);
    import xsrg_pkg::*;

    logic        s1_valid_reg, s2_valid_reg;
    job_t        s1_job_reg;
    logic [31:0] s1_off_a_reg, s1_off_b_reg;
    logic        s1_adv, s2_adv;
    logic [64:0] prod_a, prod_b;

    logic [32:0] ov_sum, ov_fold;
    logic [31:0] u_val, v_val;
    logic [63:0] word_next;
    logic [31:0] first_next, second_next;

    logic [63:0] word_reg;
    logic [31:0] first_reg, second_reg;
    logic        error_reg;

    assign s2_adv  = !s2_valid_reg || res_ready;
    assign s1_adv  = !s1_valid_reg || s2_adv;
    assign job_pop = job_valid && s1_adv;

    assign prod_a = 65'(job.draw_a) * 65'(job.width);
    assign prod_b = 65'(job.draw_b) * 65'(job.width - 33'd1);

    // Pair: offsets from begin, second folded back into [0, n).
    assign ov_sum  = {1'b0, s1_off_a_reg} + {1'b0, s1_off_b_reg} + 33'd1;
    assign ov_fold = (ov_sum >= s1_job_reg.width) ? ov_sum - s1_job_reg.width : ov_sum;
    assign u_val   = s1_job_reg.lo_bound + s1_off_a_reg;
    assign v_val   = s1_job_reg.lo_bound + ov_fold[31:0];

    always_comb
    begin
        word_next   = '0;
        first_next  = '0;
        second_next = '0;
        if (!s1_job_reg.err)
        begin
            unique case (s1_job_reg.cmd)
                CMD_RAW32:     word_next = {32'd0, s1_job_reg.draw_a};
                CMD_U64:       word_next = {s1_job_reg.draw_a, s1_job_reg.draw_b};
                CMD_HALF_OPEN: first_next = u_val;
                CMD_CLOSED:    first_next = u_val;
                CMD_PAIR:
                begin
                    if ({1'b0, s1_off_a_reg} > ov_fold)
                    begin
                        first_next  = v_val;
                        second_next = u_val;
                    end
                    else
                    begin
                        first_next  = u_val;
                        second_next = v_val;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            s1_job_reg   <= job;
            s1_off_a_reg <= prod_a[63:32];
            s1_off_b_reg <= prod_b[63:32];
        end
        if (s1_valid_reg && s2_adv)
        begin
            word_reg   <= word_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            error_reg  <= s1_job_reg.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= job_pop;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    assign res_valid  = s2_valid_reg;
    assign res_word   = word_reg;
    assign res_first  = first_reg;
    assign res_second = second_reg;
    assign res_error  = error_reg;

endmodule
`default_nettype wire
